// ----- hw/rtl/cdp_pkg.sv -----
package cdp_pkg;

  localparam int StackDepthDefault   = 64;
  localparam int TableEntriesDefault = 256;
  localparam int AddrBits            = 48;

  localparam int CfgIndexBits = 1;
  localparam int CfgDataBits  = AddrBits;
  localparam int TimeBits     = 64;
  localparam int CountBits    = 32;
  localparam int StatusBits   = 3;

  localparam logic [CfgIndexBits-1:0] CfgTriggerAddress = 1'd0;
  localparam logic [CfgIndexBits-1:0] CfgRecordingEnable = 1'd1;

  localparam logic [StatusBits-1:0] StIgnored   = 3'd0;
  localparam logic [StatusBits-1:0] StPushed    = 3'd1;
  localparam logic [StatusBits-1:0] StRecorded  = 3'd2;
  localparam logic [StatusBits-1:0] StEmpty     = 3'd3;
  localparam logic [StatusBits-1:0] StStackFull = 3'd4;
  localparam logic [StatusBits-1:0] StTableFull = 3'd5;

  typedef struct packed {
    logic                req_type;
    logic [AddrBits-1:0] func_addr;
    logic [TimeBits-1:0] time_ns;
    logic                excluded;
  } req_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic [AddrBits-1:0]   stat_addr;
    logic [TimeBits-1:0]   duration_ns;
    logic [TimeBits-1:0]   dur_min;
    logic [TimeBits-1:0]   dur_max;
    logic [CountBits-1:0]  call_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STACK_SCAN,
    S_TIME_READ,
    S_TABLE_SCAN,
    S_STAT_READ,
    S_STAT_WRITE,
    S_RESULT
  } state_t;

endpackage

// ----- hw/rtl/call_duration_profiler.sv -----
// Channel    | direction | handshake         | payload
// ---------- | --------- | ----------------- | ------------------------------
// req        | in        | req_valid/stall   | cdp_pkg::req_t
// rsp        | out       | rsp_valid/stall   | cdp_pkg::rsp_t
// cfg        | in        | cfg_we            | cfg_index, cfg_data
//
// An entry, an ignored request and an exit on an empty stack give their result
// in the cycle after acceptance; the next request is taken only once it has left.
// Any other exit walks the frame memory one frame a cycle from the top down to
// the matching frame or the bottom, then the entry memory one entry a cycle from
// entry zero to the matching key, or over every entry when there is none. Each
// memory has a single read port.
// Reset is synchronous and clears the stack pointer, the arm bit, the
// configuration and the per-entry valid bits; the memories are not cleared.
// While a result waits under rsp_stall no further request is taken.
module call_duration_profiler #(
  parameter int StackDepth   = cdp_pkg::StackDepthDefault,
  parameter int TableEntries = cdp_pkg::TableEntriesDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  cdp_pkg::req_t                      req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output cdp_pkg::rsp_t                      rsp,
  input  logic                               cfg_we,
  input  logic [cdp_pkg::CfgIndexBits-1:0]   cfg_index,
  input  logic [cdp_pkg::CfgDataBits-1:0]    cfg_data
);

  localparam int AddrBits  = cdp_pkg::AddrBits;
  localparam int SpBits    = $clog2(StackDepth + 1);
  localparam int SIdxBits  = $clog2(StackDepth);
  localparam int TIdxBits  = $clog2(TableEntries);
  localparam int TCntBits  = $clog2(TableEntries + 1);
  localparam int TimeBits  = cdp_pkg::TimeBits;
  localparam int CntBits   = cdp_pkg::CountBits;
  localparam int StatBits  = 2 * TimeBits + CntBits;
  localparam int FrameBits = AddrBits + TimeBits;
  localparam int EntryBits = AddrBits + StatBits;

  // Configuration and control state.
  logic [AddrBits-1:0]   trigger_address;
  logic                  recording_enable;
  logic                  recording_started;
  logic [SpBits-1:0]     stack_pointer;
  logic [TableEntries-1:0] entry_valid;

  cdp_pkg::state_t state, state_next;

  // Current request held for the duration of its processing.
  logic [AddrBits-1:0] cur_addr;
  logic [TimeBits-1:0] cur_time;
  logic [SpBits-1:0]   scan_j;      // frame being examined, one above index
  logic [SIdxBits-1:0] pop_idx;
  logic [TCntBits-1:0] tab_i;
  logic                free_found;
  logic [TIdxBits-1:0] free_slot;
  logic [TIdxBits-1:0] slot;
  logic                slot_new;
  logic                key_live;
  logic [TimeBits-1:0] dur;
  logic                rsp_full;
  logic                scan_prim;

  // Memories: frames as {address, time}, entries as {key, min, max, count}.
  logic                 fr_we;
  logic [SIdxBits-1:0]  fr_waddr, fr_raddr;
  logic [FrameBits-1:0] fr_rdata;
  logic [AddrBits-1:0]  fa_rdata;
  logic [TimeBits-1:0]  ft_rdata;
  logic                 en_we;
  logic [TIdxBits-1:0]  en_raddr;
  logic [EntryBits-1:0] en_wdata, en_rdata;
  logic [AddrBits-1:0]  tk_rdata;
  logic [StatBits-1:0]  ts_rdata;

  logic                  accept;
  logic                  active;
  logic                  armed_now;
  logic                  exit_scan;
  logic                  frame_hit;
  logic                  tab_end;
  logic                  tab_hit;
  logic                  slot_ok;
  logic [SIdxBits-1:0]   scan_addr;
  logic [TIdxBits-1:0]   tab_addr;
  logic [TimeBits-1:0]   old_min, old_max, new_min, new_max;
  logic [CntBits-1:0]    old_cnt, new_cnt;
  cdp_pkg::rsp_t         acc_rsp;
  cdp_pkg::rsp_t         stat_rsp;

  assign req_stall = (state != cdp_pkg::S_IDLE) || rsp_full;
  assign accept    = req_valid && !req_stall;
  assign rsp_valid = rsp_full;

  // Arming is decided on the accepted request before its own processing.
  assign armed_now = recording_started ||
                     (!req.req_type && (req.func_addr == trigger_address));
  assign active    = recording_enable && armed_now && !req.excluded;

  // An active exit with frames on the stack needs the scans; everything else
  // answers straight away.
  assign exit_scan = active && req.req_type && stack_pointer != '0 &&
                     stack_pointer <= SpBits'(StackDepth);

  assign scan_addr = SIdxBits'(scan_j - SpBits'(1));
  assign tab_addr  = tab_i[TIdxBits-1:0];
  assign frame_hit = (fa_rdata == cur_addr);
  assign tab_end   = (tab_i == TCntBits'(TableEntries));
  assign tab_hit   = !tab_end && entry_valid[tab_addr] && (tk_rdata == cur_addr);
  assign slot_ok   = !slot_new || key_live;

  assign fr_we    = accept && active && !req.req_type &&
                    (stack_pointer < SpBits'(StackDepth));
  assign fr_waddr = stack_pointer[SIdxBits-1:0];

  // The frame read address runs one frame ahead of the compare: the top frame
  // is read at the accepting edge, then the frame below the one in the data.
  always_comb begin
    case (state)
      cdp_pkg::S_STACK_SCAN: fr_raddr = SIdxBits'(scan_j - SpBits'(2));
      cdp_pkg::S_TIME_READ:  fr_raddr = pop_idx;
      default:               fr_raddr = SIdxBits'(stack_pointer - SpBits'(1));
    endcase
  end

  cdp_ram #(.Width(FrameBits), .Depth(StackDepth)) u_frame (
    .clk, .we(fr_we), .waddr(fr_waddr), .wdata({req.func_addr, req.time_ns}),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  assign fa_rdata = fr_rdata[FrameBits-1 -: AddrBits];
  assign ft_rdata = fr_rdata[TimeBits-1:0];

  // Likewise the key read runs one entry ahead of the table scan.
  always_comb begin
    case (state)
      cdp_pkg::S_TABLE_SCAN: en_raddr = TIdxBits'(tab_i + TCntBits'(1));
      cdp_pkg::S_STAT_READ:  en_raddr = slot;
      default:               en_raddr = '0;
    endcase
  end

  // An exit that finds neither its key nor a free entry leaves every entry untouched.
  assign en_we    = (state == cdp_pkg::S_STAT_WRITE) && slot_ok;
  assign en_wdata = {cur_addr, new_min, new_max, new_cnt};

  cdp_ram #(.Width(EntryBits), .Depth(TableEntries)) u_entry (
    .clk, .we(en_we), .waddr(slot), .wdata(en_wdata),
    .raddr(en_raddr), .rdata(en_rdata)
  );

  assign tk_rdata = en_rdata[EntryBits-1 -: AddrBits];
  assign ts_rdata = en_rdata[StatBits-1:0];

  // Statistics update; a freshly claimed entry starts from a zero count.
  assign old_min = ts_rdata[StatBits-1 -: TimeBits];
  assign old_max = ts_rdata[CntBits +: TimeBits];
  assign old_cnt = slot_new ? '0 : ts_rdata[CntBits-1:0];
  assign new_min = (old_cnt == '0 || dur < old_min) ? dur : old_min;
  assign new_max = (old_cnt == '0 || dur > old_max) ? dur : old_max;
  assign new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + CntBits'(1);

  // Result of a request answered at acceptance.
  always_comb begin
    acc_rsp = '0;
    if (active) begin
      acc_rsp.stat_addr = req.func_addr;
      if (!req.req_type) begin
        acc_rsp.status = (stack_pointer < SpBits'(StackDepth)) ?
                         cdp_pkg::StPushed : cdp_pkg::StStackFull;
      end else begin
        acc_rsp.status = cdp_pkg::StEmpty;
      end
    end
  end

  // Result of an exit that went through both scans.
  always_comb begin
    stat_rsp           = '0;
    stat_rsp.stat_addr = cur_addr;
    if (slot_ok) begin
      stat_rsp.status      = cdp_pkg::StRecorded;
      stat_rsp.duration_ns = dur;
      stat_rsp.dur_min     = new_min;
      stat_rsp.dur_max     = new_max;
      stat_rsp.call_count  = new_cnt;
    end else begin
      stat_rsp.status = cdp_pkg::StTableFull;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      cdp_pkg::S_IDLE: begin
        if (accept && exit_scan) begin
          state_next = cdp_pkg::S_STACK_SCAN;
        end
      end
      cdp_pkg::S_STACK_SCAN: begin
        // The data on the read port is the frame just below scan_j.
        if (frame_hit || scan_j == SpBits'(1)) begin
          state_next = cdp_pkg::S_TIME_READ;
        end
      end
      cdp_pkg::S_TIME_READ: state_next = cdp_pkg::S_TABLE_SCAN;
      cdp_pkg::S_TABLE_SCAN: begin
        if (tab_end || tab_hit) begin
          state_next = cdp_pkg::S_STAT_READ;
        end
      end
      cdp_pkg::S_STAT_READ: state_next = cdp_pkg::S_STAT_WRITE;
      cdp_pkg::S_STAT_WRITE: state_next = cdp_pkg::S_IDLE;
      default: state_next = cdp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= cdp_pkg::S_IDLE;
      trigger_address   <= '0;
      recording_enable  <= 1'b0;
      recording_started <= 1'b0;
      stack_pointer     <= '0;
      entry_valid       <= '0;
      rsp_full          <= 1'b0;
      scan_prim         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          cdp_pkg::CfgTriggerAddress: trigger_address <= cfg_data[AddrBits-1:0];
          cdp_pkg::CfgRecordingEnable: recording_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (rsp_full && !rsp_stall) begin
        rsp_full <= 1'b0;
      end
      if (accept) begin
        recording_started <= armed_now;
        if (active && !req.req_type && stack_pointer < SpBits'(StackDepth)) begin
          stack_pointer <= stack_pointer + SpBits'(1);
        end
        if (active && req.req_type &&
            (stack_pointer == '0 || stack_pointer > SpBits'(StackDepth))) begin
          stack_pointer <= '0;
        end
        if (!exit_scan) begin
          rsp_full <= 1'b1;
        end
      end
      if (state == cdp_pkg::S_STACK_SCAN && state_next == cdp_pkg::S_TIME_READ) begin
        stack_pointer <= frame_hit ? SpBits'(scan_addr) : SpBits'(pop_idx);
      end
      if (state == cdp_pkg::S_STAT_WRITE) begin
        if (slot_new && key_live) begin
          entry_valid[slot] <= 1'b1;
        end
        rsp_full <= 1'b1;
      end
      scan_prim <= (state == cdp_pkg::S_TIME_READ);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_addr <= req.func_addr;
      cur_time <= req.time_ns;
      scan_j   <= stack_pointer;
      pop_idx  <= SIdxBits'(stack_pointer - SpBits'(1));
      rsp      <= acc_rsp;
    end
    case (state)
      cdp_pkg::S_STACK_SCAN: begin
        if (frame_hit) begin
          pop_idx <= scan_addr;
        end
        scan_j <= scan_j - SpBits'(1);
      end
      cdp_pkg::S_TIME_READ: begin
        tab_i      <= '0;
        key_live   <= 1'b0;
        free_found <= 1'b0;
        free_slot  <= '0;
      end
      cdp_pkg::S_TABLE_SCAN: begin
        // The popped frame's time arrives in the first scan cycle.
        if (scan_prim) begin
          dur <= cur_time - ft_rdata;
        end
        if (!tab_end && !entry_valid[tab_addr] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= tab_addr;
        end
        if (tab_hit) begin
          slot     <= tab_addr;
          slot_new <= 1'b0;
        end else if (tab_end) begin
          slot     <= free_slot;
          slot_new <= 1'b1;
          key_live <= free_found;
        end
        if (!tab_end) begin
          tab_i <= tab_i + TCntBits'(1);
        end
      end
      cdp_pkg::S_STAT_WRITE: begin
        rsp <= stat_rsp;
      end
      default: ;
    endcase
  end

  property p_busy_stalls;
    @(posedge clk) disable iff (rst)
      (state != cdp_pkg::S_IDLE) |-> req_stall;
  endproperty
  a_busy_stalls: assert property (p_busy_stalls) else $error("request taken while busy");

  property p_sp_bound;
    @(posedge clk) disable iff (rst) stack_pointer <= SpBits'(StackDepth);
  endproperty
  a_sp_bound: assert property (p_sp_bound) else $error("stack pointer beyond depth");

  property p_result_holds;
    @(posedge clk) disable iff (rst)
      (rsp_full && rsp_stall) |=> rsp_full;
  endproperty
  a_result_holds: assert property (p_result_holds) else $error("result lost");

endmodule

// ----- hw/rtl/cdp_ram.sv -----
module cdp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sim/tb_call_duration_profiler.sv -----
`timescale 1ns / 100ps

module tb_call_duration_profiler;

  localparam int StackDepth   = cdp_pkg::StackDepthDefault;
  localparam int TableEntries = cdp_pkg::TableEntriesDefault;
  localparam int IdleLimit    = 5000;
  localparam int DrainCycles  = 400;
  localparam int HoldCycles   = 200;

  // The profiler's behaviour is mirrored here request by request. Each
  // accepted request yields exactly one expected result, kept in order.
  class profile_scoreboard;
    bit [47:0] trig_addr;
    bit        rec_en;
    bit        armed;
    bit [47:0] frame_addr [StackDepth];
    bit [63:0] frame_time [StackDepth];
    int        depth;
    bit        slot_used [TableEntries];
    bit [47:0] slot_key [TableEntries];
    bit [63:0] slot_min [TableEntries];
    bit [63:0] slot_max [TableEntries];
    bit [31:0] slot_count [TableEntries];
    cdp_pkg::rsp_t expected_q [$];
    int        failures;
    int        status_seen [8];

    function void write_reg(logic [cdp_pkg::CfgIndexBits-1:0] idx,
                            logic [cdp_pkg::CfgDataBits-1:0] val);
      if (idx == cdp_pkg::CfgTriggerAddress) trig_addr = val;
      else if (idx == cdp_pkg::CfgRecordingEnable) rec_en = val[0];
    endfunction

    function void note_request(cdp_pkg::req_t r);
      cdp_pkg::rsp_t e;
      int   top;
      int   slot;
      bit [63:0] dur;
      e = '0;
      if (!r.req_type && r.func_addr == trig_addr) armed = 1;
      if (rec_en && armed && !r.excluded) begin
        e.stat_addr = r.func_addr;
        if (!r.req_type) begin
          if (depth >= StackDepth) begin
            e.status = cdp_pkg::StStackFull;
          end else begin
            frame_addr[depth] = r.func_addr;
            frame_time[depth] = r.time_ns;
            depth++;
            e.status = cdp_pkg::StPushed;
          end
        end else if (depth == 0) begin
          e.status = cdp_pkg::StEmpty;
        end else begin
          // Search down from the top; an unmatched exit takes the top frame.
          top = depth - 1;
          for (int j = depth - 1; j >= 0; j--) begin
            if (frame_addr[j] == r.func_addr) begin
              top = j;
              break;
            end
          end
          dur = r.time_ns - frame_time[top];
          depth = top;
          slot = -1;
          for (int i = 0; i < TableEntries; i++) begin
            if (slot_used[i] && slot_key[i] == r.func_addr) begin
              slot = i;
              break;
            end
          end
          if (slot < 0) begin
            for (int i = 0; i < TableEntries; i++) begin
              if (!slot_used[i]) begin
                slot = i;
                slot_used[i] = 1;
                slot_key[i] = r.func_addr;
                slot_count[i] = 0;
                break;
              end
            end
          end
          if (slot < 0) begin
            e.status = cdp_pkg::StTableFull;
          end else begin
            if (slot_count[slot] == 0) begin
              slot_min[slot] = dur;
              slot_max[slot] = dur;
            end else begin
              if (dur < slot_min[slot]) slot_min[slot] = dur;
              if (dur > slot_max[slot]) slot_max[slot] = dur;
            end
            if (slot_count[slot] != 32'hFFFF_FFFF) slot_count[slot]++;
            e.status      = cdp_pkg::StRecorded;
            e.duration_ns = dur;
            e.dur_min     = slot_min[slot];
            e.dur_max     = slot_max[slot];
            e.call_count  = slot_count[slot];
          end
        end
      end
      status_seen[e.status]++;
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void check_result(cdp_pkg::rsp_t a);
      cdp_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d addr %h", a.status, a.stat_addr);
        failures++;
        return;
      end
      e = expected_q.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        failures++;
      end
      if (a.stat_addr !== e.stat_addr) begin
        $error("stat_addr: expected %h, got %h", e.stat_addr, a.stat_addr);
        failures++;
      end
      if (a.duration_ns !== e.duration_ns) begin
        $error("duration_ns: expected %0d, got %0d", e.duration_ns, a.duration_ns);
        failures++;
      end
      if (a.dur_min !== e.dur_min) begin
        $error("dur_min: expected %0d, got %0d", e.dur_min, a.dur_min);
        failures++;
      end
      if (a.dur_max !== e.dur_max) begin
        $error("dur_max: expected %0d, got %0d", e.dur_max, a.dur_max);
        failures++;
      end
      if (a.call_count !== e.call_count) begin
        $error("call_count: expected %0d, got %0d", e.call_count, a.call_count);
        failures++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             req_valid;
  logic                             req_stall;
  cdp_pkg::req_t                    req;
  logic                             rsp_valid;
  logic                             rsp_stall;
  cdp_pkg::rsp_t                    rsp;
  logic                             cfg_we;
  logic [cdp_pkg::CfgIndexBits-1:0] cfg_index;
  logic [cdp_pkg::CfgDataBits-1:0]  cfg_data;

  profile_scoreboard sb;
  bit        quiet;       // no idling on either side in the closing part of the run
  bit        hold_rsp;    // asks the receiver for one long hold-off
  bit [63:0] now_ns;      // running timestamp for well-formed call sequences
  int        idle_count;

  call_duration_profiler i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one request and returns at the edge where it is taken. A gap with
  // req_valid low may be inserted first, so gaps land on every phase.
  task automatic send_request(bit is_exit, bit [47:0] addr, bit [63:0] ts, bit excl);
    cdp_pkg::req_t r;
    r.req_type  = is_exit;
    r.func_addr = addr;
    r.time_ns   = ts;
    r.excluded  = excl;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!(req_valid && !req_stall));
    sb.note_request(r);
  endtask

  // Calls advance the running clock by a small random step.
  task automatic call_event(bit is_exit, bit [47:0] addr);
    now_ns += 64'($urandom_range(1, 2000));
    send_request(is_exit, addr, now_ns, 1'b0);
  endtask

  // Registers are only written once every result is back and the block has
  // had time to settle.
  task automatic write_reg(logic [cdp_pkg::CfgIndexBits-1:0] idx,
                           logic [cdp_pkg::CfgDataBits-1:0] val);
    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random stall bursts, one long hold-off on request, and the
  // check of every result taken.
  initial begin
    int burst;
    int hold;
    burst = 0;
    hold  = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
      if (hold_rsp && hold == 0) begin
        hold     = HoldCycles;
        hold_rsp = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        rsp_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 2);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  initial begin
    idle_count = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count = 0;
      else idle_count++;
      if (idle_count >= IdleLimit) begin
        $display("timeout: nothing accepted for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    bit [47:0] stack_shadow [$];
    bit [47:0] addr;
    bit        is_exit;
    sb        = new();
    quiet     = 1'b0;
    hold_rsp  = 1'b0;
    now_ns    = 64'd1000;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight after reset recording is disabled: everything is ignored,
    // though the entry of address zero (the reset trigger) arms recording.
    call_event(1'b0, 48'h0000_0000_0000);
    call_event(1'b1, 48'h0000_0000_0000);

    // Directed part with the trigger at the top of the address range.
    write_reg(cdp_pkg::CfgTriggerAddress, 48'hFFFF_FFFF_FFFF);
    write_reg(cdp_pkg::CfgRecordingEnable, 48'd1);
    call_event(1'b1, 48'h0000_0000_0010);          // exit with an empty stack
    call_event(1'b0, 48'h0000_0000_0010);
    call_event(1'b0, 48'hFFFF_FFFF_FFFF);          // the trigger entry is pushed
    send_request(1'b0, 48'h0000_0000_0020, now_ns, 1'b1);   // excluded entry
    call_event(1'b0, 48'h0000_0000_0030);
    call_event(1'b1, 48'h0000_0000_0030);          // matched exit
    call_event(1'b0, 48'h0000_0000_0030);
    call_event(1'b1, 48'h0000_0000_0030);          // second call updates the entry's statistics
    send_request(1'b1, 48'h0000_0000_0030, now_ns, 1'b1);   // excluded exit
    call_event(1'b1, 48'h0000_0000_0055);          // unmatched exit pops the top frame
    call_event(1'b1, 48'h0000_0000_0055);          // and the next one empties the stack
    // Timestamp wrap: the end time is below the start time; then a call over the full range.
    send_request(1'b0, 48'h0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    send_request(1'b1, 48'h0000_0000_0000, 64'h0000_0000_0000_0005, 1'b0);
    send_request(1'b0, 48'h8000_0000_0001, 64'h0, 1'b0);
    send_request(1'b1, 48'h8000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);

    // Stack full: two entries beyond the depth are refused, then one exit of
    // the bottom frame unwinds the whole stack.
    for (int i = 0; i < StackDepth + 2; i++) call_event(1'b0, 48'h100 + 48'(i));
    call_event(1'b1, 48'h100);

    // Recording disabled again: requests are ignored and state is kept.
    write_reg(cdp_pkg::CfgRecordingEnable, 48'd0);
    call_event(1'b0, 48'h0000_0000_0030);
    call_event(1'b1, 48'h0000_0000_0030);
    write_reg(cdp_pkg::CfgTriggerAddress, 48'({$urandom, $urandom}));
    write_reg(cdp_pkg::CfgRecordingEnable, 48'd1);

    // Random part: mostly nested calls from a small pool of functions, with
    // noise of random addresses, kinds, timestamps and exclusions.
    for (int n = 0; n < 450; n++) begin
      if (n == 100) hold_rsp = 1'b1;   // long hold-off while requests keep coming
      if ($urandom_range(0, 99) < 15) begin
        send_request(1'($urandom_range(0, 1)), 48'({$urandom, $urandom}),
                     {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      end else begin
        is_exit = stack_shadow.size() > 0 &&
                  (stack_shadow.size() >= 24 || $urandom_range(0, 1) == 1);
        if (is_exit) begin
          addr = stack_shadow.pop_back();
          if ($urandom_range(0, 9) == 0) addr = 48'($urandom_range(0, 47));
        end else begin
          addr = 48'($urandom_range(0, 47));
          stack_shadow.insert(stack_shadow.size(), addr);
        end
        now_ns += 64'($urandom_range(1, 2000));
        send_request(is_exit, addr, now_ns, $urandom_range(0, 19) == 0);
      end
    end

    // Closing part without idling: enough distinct functions to fill the
    // statistics table, so the last calls are refused for want of an entry.
    write_reg(cdp_pkg::CfgTriggerAddress, 48'h0);
    quiet = 1'b1;
    for (int i = 0; i < 230; i++) begin
      call_event(1'b0, 48'h1000_0000 + 48'(i));
      call_event(1'b1, 48'h1000_0000 + 48'(i));
    end
    req_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d ignored, %0d pushed, %0d recorded, %0d empty-stack exits,",
             sb.status_seen[cdp_pkg::StIgnored], sb.status_seen[cdp_pkg::StPushed],
             sb.status_seen[cdp_pkg::StRecorded], sb.status_seen[cdp_pkg::StEmpty]);
    $display("%0d stack-full and %0d table-full events over several register settings.",
             sb.status_seen[cdp_pkg::StStackFull], sb.status_seen[cdp_pkg::StTableFull]);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
